>>> hw/rtl/timer_wheel_with_overflow_heap_assert.svh
// ---------------------------------------------------------------------------
// timer wheel assertion macros
// clocked assertion helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef TIMER_WHEEL_WITH_OVERFLOW_HEAP_ASSERT_SVH
`define TIMER_WHEEL_WITH_OVERFLOW_HEAP_ASSERT_SVH
`ifndef SYNTH
`define TWH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timer wheel check failed");
`define TWH_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("timer wheel forbidden condition");
`else
`define TWH_ASSERT(lbl, prop)
`define TWH_NEVER(lbl, cond)
`endif
`endif

>>> hw/rtl/twh_pkg.sv
// ---------------------------------------------------------------------------
// twh_pkg
// shared widths and codes for the timer wheel block
// ---------------------------------------------------------------------------
package twh_pkg;

    localparam int WHEEL_SLOTS   = 256;
    localparam int TIMER_ENTRIES = 32;
    localparam int SLOT_W        = $clog2(WHEEL_SLOTS);
    localparam int ID_W          = 5;
    localparam int LINK_W        = ID_W + 1;
    localparam int TIME_W        = 64;
    localparam int DELAY_W       = 32;
    localparam int CNT_W         = $clog2(TIMER_ENTRIES) + 1;

    localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};

    localparam logic [1:0] FN_SCHED  = 2'd0;
    localparam logic [1:0] FN_CANCEL = 2'd1;
    localparam logic [1:0] FN_TICK   = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;
    localparam logic [1:0] ST_NOTSCH = 2'd3;

    localparam logic [1:0] PL_IDLE  = 2'd0;
    localparam logic [1:0] PL_WHEEL = 2'd1;
    localparam logic [1:0] PL_HEAP  = 2'd2;

endpackage

>>> hw/rtl/twh_if.sv
// ---------------------------------------------------------------------------
// twh_if
// request and result channels of the timer wheel block
// ---------------------------------------------------------------------------
interface twh_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic [twh_pkg::ID_W-1:0]        timer_id;
    logic [twh_pkg::DELAY_W-1:0]     delay_ticks;

    modport source (output valid, func, timer_id, delay_ticks, input ready);
    modport sink   (input valid, func, timer_id, delay_ticks, output ready);
endinterface

interface twh_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [twh_pkg::ID_W-1:0]        expired_id;
    logic                            fired;
    logic [1:0]                      status;
    logic                            last;

    modport source (output valid, expired_id, fired, status, last, input ready);
    modport sink   (input valid, expired_id, fired, status, last, output ready);
endinterface

>>> hw/rtl/timer_wheel_with_overflow_heap.sv
// ---------------------------------------------------------------------------
// timer_wheel_with_overflow_heap
// hashed timing wheel with an unordered overflow store scanned for minimum
// ---------------------------------------------------------------------------
// usage
//   req carries one command word: schedule, cancel or tick. req.ready is high
//   only while the sequencer is idle; one command is worked at a time.
//   rsp carries result words; the final word of a command has last set.
//   schedule and cancel: one word.
//   tick: each timer taken from the current slot list passes S_T_WRD and
//   S_T_WEM, then every far timer popped costs one scan of the overflow store
//   (S_H_START, S_H_SCAN, S_H_CHK) and one S_H_REM step to remove it.
//   results leave through a one-word output register, and a tick keeps one
//   more word back so that last can be marked; a stalled rsp.ready holds the
//   sequencer only where it must hand over a word.
//   reset: now is zero, all timers idle, all slots empty (per-slot valid
//   flops, no clearing pass), overflow store empty.
// ---------------------------------------------------------------------------
`include "timer_wheel_with_overflow_heap_assert.svh"

module timer_wheel_with_overflow_heap (
    input  logic      clk,
    input  logic      rst_n,
    twh_req_if.sink   req,
    twh_rsp_if.source rsp
);

    localparam int NS = 19;

    typedef enum logic [NS-1:0] {
        S_IDLE     = NS'(1) << 0,
        S_DEC      = NS'(1) << 1,
        S_SCH_RD   = NS'(1) << 2,
        S_SCH_LINK = NS'(1) << 3,
        S_SCH_HP   = NS'(1) << 4,
        S_CAN_RD   = NS'(1) << 5,
        S_CAN_SRD  = NS'(1) << 6,
        S_CAN_W    = NS'(1) << 7,
        S_CAN_HW   = NS'(1) << 8,
        S_RES      = NS'(1) << 9,
        S_T_SRD    = NS'(1) << 10,
        S_T_SLOT   = NS'(1) << 11,
        S_T_WRD    = NS'(1) << 12,
        S_T_WEM    = NS'(1) << 13,
        S_H_START  = NS'(1) << 14,
        S_H_SCAN   = NS'(1) << 15,
        S_H_CHK    = NS'(1) << 16,
        S_H_REM    = NS'(1) << 17,
        S_T_END    = NS'(1) << 18
    } state_t;

    localparam int IW = twh_pkg::ID_W;
    localparam int LW = twh_pkg::LINK_W;
    localparam int SW = twh_pkg::SLOT_W;
    localparam int TW = twh_pkg::TIME_W;
    localparam int CW = twh_pkg::CNT_W;
    localparam int NE = twh_pkg::TIMER_ENTRIES;
    localparam int NW = twh_pkg::WHEEL_SLOTS;
    localparam logic [twh_pkg::DELAY_W-1:0] NEAR_LIM = twh_pkg::DELAY_W'(NW - 1);

    state_t state_reg, state_next;

    logic [1:0]                  func_reg;
    logic [IW-1:0]               id_reg;
    logic [twh_pkg::DELAY_W-1:0] delay_reg;
    logic [1:0]                  st_reg, st_next;
    logic [TW-1:0]               exp_reg, exp_next;
    logic [TW-1:0]               now_reg, now_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               k_reg, k_next;
    logic [LW-1:0]               cur_reg, cur_next;
    logic                        pend_vld_reg, pend_vld_next;
    logic [IW-1:0]               pend_id_reg, pend_id_next;
    logic                        best_vld_reg, best_vld_next;
    logic [TW-1:0]               best_exp_reg, best_exp_next;
    logic [IW-1:0]               best_id_reg, best_id_next;
    logic [IW-1:0]               best_pos_reg, best_pos_next;
    logic [CW-1:0]               scan_reg, scan_next;
    logic                        qv_reg, qv_next;
    logic [IW-1:0]               qpos_reg, qpos_next;
    logic [1:0]                  place_reg [NE];
    logic [1:0]                  place_next [NE];

    logic          out_vld_reg;
    logic [IW-1:0] out_id_reg;
    logic          out_fired_reg;
    logic [1:0]    out_st_reg;
    logic          out_last_reg;
    logic          out_load;
    logic [IW-1:0] ld_id;
    logic          ld_fired;
    logic [1:0]    ld_st;
    logic          ld_last;
    logic          o_free;
    logic          emit_ok;

    // slot memory: {head, tail}
    logic [2*LW-1:0] slot_mem [NW];
    logic            slot_vld_reg [NW];
    logic [SW-1:0]   slot_raddr, slot_waddr;
    logic [2*LW-1:0] slot_q, slot_wdata;
    logic            slot_qv, slot_we, slot_clr;
    logic [LW-1:0]   slot_head_q, slot_tail_q;

    logic [LW-1:0] nxt_mem [NE];
    logic [IW-1:0] nxt_raddr, nxt_waddr;
    logic [LW-1:0] nxt_q, nxt_wdata;
    logic          nxt_we;

    logic [LW-1:0] prv_mem [NE];
    logic [IW-1:0] prv_waddr;
    logic [LW-1:0] prv_q, prv_wdata;
    logic          prv_we;

    logic [SW-1:0] eslot_mem [NE];
    logic [SW-1:0] eslot_q;
    logic          eslot_we;

    // overflow store: {id, expiry} by position
    logic [IW+TW-1:0] h_mem [NE];
    logic [IW-1:0]    h_raddr, h_waddr;
    logic [IW+TW-1:0] h_q, h_wdata;
    logic             h_we;
    logic [IW-1:0]    hq_id;
    logic [TW-1:0]    hq_exp;

    logic [IW-1:0] hpos_mem [NE];
    logic [IW-1:0] hpos_waddr, hpos_wdata, hpos_q;
    logic          hpos_we;

    logic [CW-1:0] count_m1;
    logic          take;

    assign o_free      = !out_vld_reg || rsp.ready;
    assign emit_ok     = !pend_vld_reg || o_free;
    assign slot_head_q = slot_qv ? slot_q[2*LW-1:LW] : twh_pkg::NIL;
    assign slot_tail_q = slot_qv ? slot_q[LW-1:0] : twh_pkg::NIL;
    assign hq_id       = h_q[IW+TW-1:TW];
    assign hq_exp      = h_q[TW-1:0];
    assign count_m1    = count_reg - CW'(1);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_vld_reg;
    assign rsp.expired_id = out_id_reg;
    assign rsp.fired      = out_fired_reg;
    assign rsp.status     = out_st_reg;
    assign rsp.last       = out_last_reg;

    // read address selection
    always_comb
    begin
        if (state_reg == S_SCH_RD || state_reg == S_SCH_LINK)
            slot_raddr = exp_reg[SW-1:0];
        else if (state_reg == S_CAN_SRD || state_reg == S_CAN_W)
            slot_raddr = eslot_q;
        else
            slot_raddr = now_reg[SW-1:0];

        if (state_reg == S_T_WRD || state_reg == S_T_WEM)
            nxt_raddr = cur_reg[IW-1:0];
        else
            nxt_raddr = id_reg;

        if (state_reg == S_H_SCAN)
            h_raddr = scan_reg[IW-1:0];
        else
            h_raddr = count_m1[IW-1:0];
    end

    // candidate of the minimum scan
    always_comb
    begin
        take = !best_vld_reg || (hq_exp < best_exp_reg) ||
               ((hq_exp == best_exp_reg) && (hq_id < best_id_reg));
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        exp_next      = exp_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        cur_next      = cur_reg;
        pend_vld_next = pend_vld_reg;
        pend_id_next  = pend_id_reg;
        best_vld_next = best_vld_reg;
        best_exp_next = best_exp_reg;
        best_id_next  = best_id_reg;
        best_pos_next = best_pos_reg;
        scan_next     = scan_reg;
        qv_next       = 1'b0;
        qpos_next     = qpos_reg;
        place_next    = place_reg;

        out_load = 1'b0;
        ld_id    = id_reg;
        ld_fired = 1'b0;
        ld_st    = st_reg;
        ld_last  = 1'b1;

        slot_we    = 1'b0;
        slot_clr   = 1'b0;
        slot_waddr = slot_raddr;
        slot_wdata = {twh_pkg::NIL, twh_pkg::NIL};
        nxt_we     = 1'b0;
        nxt_waddr  = id_reg;
        nxt_wdata  = twh_pkg::NIL;
        prv_we     = 1'b0;
        prv_waddr  = id_reg;
        prv_wdata  = twh_pkg::NIL;
        eslot_we   = 1'b0;
        h_we       = 1'b0;
        h_waddr    = count_reg[IW-1:0];
        h_wdata    = {id_reg, exp_reg};
        hpos_we    = 1'b0;
        hpos_waddr = id_reg;
        hpos_wdata = count_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                st_next = twh_pkg::ST_OK;
                unique case (func_reg)
                    twh_pkg::FN_SCHED:
                    begin
                        exp_next = now_reg + TW'(delay_reg) + TW'(1);
                        if (delay_reg == '0)
                        begin
                            st_next    = twh_pkg::ST_ZERO;
                            state_next = S_RES;
                        end
                        else if (place_reg[id_reg] != twh_pkg::PL_IDLE)
                        begin
                            st_next    = twh_pkg::ST_BUSY;
                            state_next = S_RES;
                        end
                        else if (delay_reg < NEAR_LIM)
                            state_next = S_SCH_RD;
                        else
                            state_next = S_SCH_HP;
                    end
                    twh_pkg::FN_CANCEL:
                    begin
                        if (place_reg[id_reg] == twh_pkg::PL_IDLE)
                        begin
                            st_next    = twh_pkg::ST_NOTSCH;
                            state_next = S_RES;
                        end
                        else
                            state_next = S_CAN_RD;
                    end
                    twh_pkg::FN_TICK:
                    begin
                        now_next   = now_reg + TW'(1);
                        k_next     = '0;
                        state_next = S_T_SRD;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SCH_RD:
            begin
                nxt_we     = 1'b1;
                eslot_we   = 1'b1;
                state_next = S_SCH_LINK;
            end
            S_SCH_LINK:
            begin
                prv_we     = 1'b1;
                prv_wdata  = slot_tail_q;
                slot_we    = 1'b1;
                slot_wdata = {(slot_tail_q == twh_pkg::NIL) ? LW'(id_reg) : slot_head_q,
                              LW'(id_reg)};
                if (slot_tail_q != twh_pkg::NIL)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = slot_tail_q[IW-1:0];
                    nxt_wdata = LW'(id_reg);
                end
                place_next[id_reg] = twh_pkg::PL_WHEEL;
                state_next = S_RES;
            end
            S_SCH_HP:
            begin
                h_we       = 1'b1;
                hpos_we    = 1'b1;
                count_next = count_reg + CW'(1);
                place_next[id_reg] = twh_pkg::PL_HEAP;
                state_next = S_RES;
            end
            S_CAN_RD:
            begin
                if (place_reg[id_reg] == twh_pkg::PL_WHEEL)
                    state_next = S_CAN_SRD;
                else
                    state_next = S_CAN_HW;
            end
            S_CAN_SRD:
                state_next = S_CAN_W;
            S_CAN_W:
            begin
                slot_waddr = eslot_q;
                slot_wdata = {(prv_q == twh_pkg::NIL) ? nxt_q : slot_head_q,
                              (nxt_q == twh_pkg::NIL) ? prv_q : slot_tail_q};
                slot_we    = (prv_q == twh_pkg::NIL) || (nxt_q == twh_pkg::NIL);
                if (prv_q != twh_pkg::NIL)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_q[IW-1:0];
                    nxt_wdata = nxt_q;
                end
                if (nxt_q != twh_pkg::NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_q[IW-1:0];
                    prv_wdata = prv_q;
                end
                place_next[id_reg] = twh_pkg::PL_IDLE;
                state_next = S_RES;
            end
            S_CAN_HW:
            begin
                h_we       = 1'b1;
                h_waddr    = hpos_q;
                h_wdata    = h_q;
                hpos_we    = 1'b1;
                hpos_waddr = hq_id;
                hpos_wdata = hpos_q;
                count_next = count_m1;
                place_next[id_reg] = twh_pkg::PL_IDLE;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (o_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_T_SRD:
                state_next = S_T_SLOT;
            S_T_SLOT:
            begin
                cur_next   = slot_head_q;
                slot_clr   = 1'b1;
                state_next = S_T_WRD;
            end
            S_T_WRD:
            begin
                if (cur_reg[LW-1])
                    state_next = S_H_START;
                else
                    state_next = S_T_WEM;
            end
            S_T_WEM:
            begin
                if (emit_ok)
                begin
                    if (pend_vld_reg)
                    begin
                        out_load = 1'b1;
                        ld_id    = pend_id_reg;
                        ld_fired = 1'b1;
                        ld_st    = twh_pkg::ST_OK;
                        ld_last  = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_id_next  = cur_reg[IW-1:0];
                    k_next        = k_reg + CW'(1);
                    place_next[cur_reg[IW-1:0]] = twh_pkg::PL_IDLE;
                    cur_next   = nxt_q;
                    state_next = S_T_WRD;
                end
            end
            S_H_START:
            begin
                if (count_reg == '0 || k_reg[CW-1])
                    state_next = S_T_END;
                else
                begin
                    scan_next     = '0;
                    best_vld_next = 1'b0;
                    state_next    = S_H_SCAN;
                end
            end
            S_H_SCAN:
            begin
                if (qv_reg && take)
                begin
                    best_vld_next = 1'b1;
                    best_exp_next = hq_exp;
                    best_id_next  = hq_id;
                    best_pos_next = qpos_reg;
                end
                if (scan_reg < count_reg)
                begin
                    qv_next   = 1'b1;
                    qpos_next = scan_reg[IW-1:0];
                    scan_next = scan_reg + CW'(1);
                end
                else
                    state_next = S_H_CHK;
            end
            S_H_CHK:
            begin
                if (now_reg < best_exp_reg)
                    state_next = S_T_END;
                else
                    state_next = S_H_REM;
            end
            S_H_REM:
            begin
                if (emit_ok)
                begin
                    if (pend_vld_reg)
                    begin
                        out_load = 1'b1;
                        ld_id    = pend_id_reg;
                        ld_fired = 1'b1;
                        ld_st    = twh_pkg::ST_OK;
                        ld_last  = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_id_next  = best_id_reg;
                    k_next        = k_reg + CW'(1);
                    h_we          = 1'b1;
                    h_waddr       = best_pos_reg;
                    h_wdata       = h_q;
                    hpos_we       = 1'b1;
                    hpos_waddr    = hq_id;
                    hpos_wdata    = best_pos_reg;
                    count_next    = count_m1;
                    place_next[best_id_reg] = twh_pkg::PL_IDLE;
                    state_next = S_H_START;
                end
            end
            S_T_END:
            begin
                if (!pend_vld_reg)
                    state_next = S_IDLE;
                else if (o_free)
                begin
                    out_load      = 1'b1;
                    ld_id         = pend_id_reg;
                    ld_fired      = 1'b1;
                    ld_st         = twh_pkg::ST_OK;
                    ld_last       = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            now_reg      <= '0;
            count_reg    <= '0;
            pend_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            qv_reg       <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int i = 0; i < NE; i++)
                place_reg[i] <= twh_pkg::PL_IDLE;
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            count_reg    <= count_next;
            pend_vld_reg <= pend_vld_next;
            best_vld_reg <= best_vld_next;
            qv_reg       <= qv_next;
            place_reg    <= place_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            func_reg  <= req.func;
            id_reg    <= req.timer_id;
            delay_reg <= req.delay_ticks;
        end
        st_reg       <= st_next;
        exp_reg      <= exp_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        pend_id_reg  <= pend_id_next;
        best_exp_reg <= best_exp_next;
        best_id_reg  <= best_id_next;
        best_pos_reg <= best_pos_next;
        scan_reg     <= scan_next;
        qpos_reg     <= qpos_next;
        if (out_load)
        begin
            out_id_reg    <= ld_id;
            out_fired_reg <= ld_fired;
            out_st_reg    <= ld_st;
            out_last_reg  <= ld_last;
        end
    end

    // slot valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
                slot_vld_reg[i] <= 1'b0;
        end
        else if (slot_we)
            slot_vld_reg[slot_waddr] <= 1'b1;
        else if (slot_clr)
            slot_vld_reg[slot_raddr] <= 1'b0;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_q  <= slot_mem[slot_raddr];
        slot_qv <= slot_vld_reg[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_waddr] <= nxt_wdata;
        nxt_q <= nxt_mem[nxt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
            prv_mem[prv_waddr] <= prv_wdata;
        prv_q <= prv_mem[id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (eslot_we)
            eslot_mem[id_reg] <= exp_reg[SW-1:0];
        eslot_q <= eslot_mem[id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            h_mem[h_waddr] <= h_wdata;
        h_q <= h_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hpos_we)
            hpos_mem[hpos_waddr] <= hpos_wdata;
        hpos_q <= hpos_mem[id_reg];
    end

    // checks
    `TWH_NEVER(a_count_range, count_reg > CW'(NE))
    `TWH_NEVER(a_pend_idle, (state_reg == S_IDLE) && pend_vld_reg)
    `TWH_ASSERT(a_plain_last, rsp.valid && !rsp.fired |-> rsp.last)
    `TWH_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready)

endmodule
